/* rtl/core/vsd_pkg.sv */
// Shared types and constants for the snapshot varint stream decoder.
package vsd_pkg;

  localparam int unsigned LONG_MAX_BYTES  = 10;
  localparam int unsigned SHORT_MAX_BYTES = 5;

  localparam int unsigned VALUE_W = 64;
  localparam int unsigned COUNT_W = 4;

  typedef enum logic [1:0] {
    FMT_UNSIGNED = 2'd0,
    FMT_REF_ID   = 2'd1,
    FMT_TAGGED32 = 2'd2,
    FMT_TAGGED64 = 2'd3
  } fmt_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERLONG = 2'd1,
    ST_CUT_OFF  = 2'd2
  } status_t;

  // One accepted input byte with its side fields.
  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] in_byte;
    logic       last_available;
  } item_t;

  // One decoded result.
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    status_t            status;
    logic [COUNT_W-1:0] bytes_used;
  } result_t;

endpackage

/* rtl/core/vsd_in_reg.sv */
// Input register stage: holds one accepted item until the decoder takes it.
module vsd_in_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          hold,
  input  vsd_pkg::item_t item_in,
  output logic          item_valid,
  output vsd_pkg::item_t item
);

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!hold) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold && in_valid) begin
      item <= item_in;
    end
  end

endmodule

/* rtl/core/vsd_core.sv */
// Decode step: value state, format latch, config register and per-byte logic.
module vsd_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_bit,
  input  logic             fire,
  input  vsd_pkg::item_t   item,
  output logic             res_valid,
  output vsd_pkg::result_t res
);

  logic                              ref_unsigned;
  logic [vsd_pkg::VALUE_W-1:0]       accumulator;
  logic [vsd_pkg::COUNT_W-1:0]       byte_index;
  vsd_pkg::fmt_t                     latched_format;

  vsd_pkg::fmt_t                     fmt_first;
  vsd_pkg::fmt_t                     fmt;
  logic [vsd_pkg::VALUE_W-1:0]       acc_cur;
  logic [vsd_pkg::VALUE_W-1:0]       acc_new;
  logic [vsd_pkg::VALUE_W-1:0]       final_val;
  logic [vsd_pkg::VALUE_W-1:0]       uns_piece;
  logic [vsd_pkg::VALUE_W-1:0]       sx_byte;
  logic [vsd_pkg::VALUE_W-1:0]       tag_piece;
  logic [7:0]                        tag_end;
  logic [6:0]                        shift7;
  logic [5:0]                        shift;
  logic [vsd_pkg::COUNT_W-1:0]       limit;
  logic [vsd_pkg::COUNT_W-1:0]       idx_next;
  logic                              is_end;
  logic [31:0]                       t32_acc;

  always_comb begin
    fmt_first = vsd_pkg::fmt_t'(item.cmd);
    if (fmt_first == vsd_pkg::FMT_REF_ID && ref_unsigned) begin
      fmt_first = vsd_pkg::FMT_UNSIGNED;
    end
    fmt     = (byte_index == '0) ? fmt_first : latched_format;
    acc_cur = (byte_index == '0) ? '0 : accumulator;

    limit = (fmt == vsd_pkg::FMT_REF_ID || fmt == vsd_pkg::FMT_TAGGED32)
          ? vsd_pkg::COUNT_W'(vsd_pkg::SHORT_MAX_BYTES)
          : vsd_pkg::COUNT_W'(vsd_pkg::LONG_MAX_BYTES);

    // 7 * index without a multiplier
    shift7 = ({3'b000, byte_index} << 3) - {3'b000, byte_index};
    shift  = shift7[5:0];

    is_end = item.in_byte[7];
    // data group is the low 7 bits whether or not this is the end byte
    uns_piece = {57'd0, item.in_byte[6:0]};
    sx_byte   = {{56{item.in_byte[7]}}, item.in_byte};
    // end byte of tagged formats contributes (byte - 0xc0), sign-extended
    tag_end   = item.in_byte + 8'h40;
    tag_piece = is_end ? {{56{tag_end[7]}}, tag_end} : sx_byte;
    t32_acc   = acc_cur[31:0] | (tag_piece[31:0] << shift);

    unique case (fmt)
      vsd_pkg::FMT_UNSIGNED: acc_new = acc_cur | (uns_piece << shift);
      vsd_pkg::FMT_REF_ID:   acc_new = (acc_cur << 7) + sx_byte;
      vsd_pkg::FMT_TAGGED32: acc_new = {32'd0, t32_acc};
      vsd_pkg::FMT_TAGGED64: acc_new = acc_cur | (tag_piece << shift);
      default:               acc_new = acc_cur;
    endcase

    final_val = (fmt == vsd_pkg::FMT_REF_ID) ? acc_new + 64'd128 : acc_new;
    idx_next  = byte_index + 1'b1;

    res_valid      = is_end || (idx_next >= limit) || item.last_available;
    res.bytes_used = idx_next;
    if (is_end) begin
      res.value  = final_val;
      res.status = vsd_pkg::ST_OK;
    end else if (idx_next >= limit) begin
      res.value  = '0;
      res.status = vsd_pkg::ST_OVERLONG;
    end else begin
      res.value  = '0;
      res.status = vsd_pkg::ST_CUT_OFF;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_unsigned <= 1'b0;
    end else if (cfg_we) begin
      ref_unsigned <= cfg_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator    <= '0;
      byte_index     <= '0;
      latched_format <= vsd_pkg::FMT_UNSIGNED;
    end else if (fire) begin
      latched_format <= fmt;
      if (res_valid) begin
        accumulator <= '0;
        byte_index  <= '0;
      end else begin
        accumulator <= acc_new;
        byte_index  <= idx_next;
      end
    end
  end

endmodule

/* rtl/core/vsd_out_reg.sv */
// Result register: holds a decoded value until the receiver takes it.
module vsd_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load_en,
  input  logic             res_valid,
  input  vsd_pkg::result_t res,
  input  logic             out_stall,
  output logic             out_valid,
  output vsd_pkg::result_t out_res
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= load_en && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if ((!out_valid || !out_stall) && load_en && res_valid) begin
      out_res <= res;
    end
  end

endmodule

/* rtl/core/snapshot_varint_stream_decoder.sv */
// Top level of the snapshot varint stream decoder.
//
// Input channel (in_valid / in_stall): one stream byte per item with cmd and
// last_available. cmd is looked at only on the first byte of a value; the
// ref_unsigned register is sampled at the same time.
// Output channel (out_valid / out_stall): one item per finished value with
// value, status (ok, overlong, cut off) and bytes_used. Error results carry
// value 0. Bytes that do not end a value give no output item.
// Config channel (cfg_valid / cfg_ready / cfg_data): writes ref_unsigned;
// cfg_ready is always high. Write only while the decoder is idle.
//
// A byte is held in the input register, decoded combinationally and its result is
// registered in the result register. Throughput: one byte per cycle when not
// stalled; the value state loops inside the decode step, between those two registers.
// When out_stall holds a full result register, a byte waiting in the input
// register is held and in_stall rises; nothing is dropped.
// Reset (rst, synchronous): clears both valid flags, the value state and
// ref_unsigned; the next byte starts a new value.
module snapshot_varint_stream_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [7:0]  in_byte,
  input  logic        last_available,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] value,
  output logic [1:0]  status,
  output logic [3:0]  bytes_used,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  vsd_pkg::item_t   item_in;
  vsd_pkg::item_t   item;
  logic             item_valid;
  logic             fire;
  logic             res_valid;
  vsd_pkg::result_t res;
  vsd_pkg::result_t out_res;

  assign item_in.cmd            = cmd;
  assign item_in.in_byte        = in_byte;
  assign item_in.last_available = last_available;

  // decode step may run whenever the result register can take its output
  assign fire      = item_valid && (!out_valid || !out_stall);
  assign in_stall  = item_valid && out_valid && out_stall;
  assign cfg_ready = 1'b1;

  vsd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .hold       (in_stall),
    .item_in    (item_in),
    .item_valid (item_valid),
    .item       (item)
  );

  vsd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_bit   (cfg_data),
    .fire      (fire),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  vsd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load_en   (fire),
    .res_valid (res_valid),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign value      = out_res.value;
  assign status     = out_res.status;
  assign bytes_used = out_res.bytes_used;

  // input back-pressure only comes from a held result
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without held result");

  // errors never carry a value
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != vsd_pkg::ST_OK) |-> (value == 64'd0))
    else $error("error result with nonzero value");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (bytes_used != 4'd0 &&
                   bytes_used <= 4'(vsd_pkg::LONG_MAX_BYTES)))
    else $error("bytes_used out of range");

  // overlong only at one of the two length limits
  a_overlong_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == vsd_pkg::ST_OVERLONG) |->
      (bytes_used == 4'(vsd_pkg::SHORT_MAX_BYTES) ||
       bytes_used == 4'(vsd_pkg::LONG_MAX_BYTES)))
    else $error("overlong result at wrong length");

endmodule
